FILE: hw/rtl/bcv_pkg.sv
// ----------------------------------------------------------------------------
// bcv_pkg
// Shared types, constants and arithmetic helpers of the Bezier curve evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package bcv_pkg;

  localparam int MAX_POINTS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int Q_W     = 17;            // Q0.16 with room for exactly 1.0
  localparam int COORD_W = 16;            // signed Q2.14 coordinate
  localparam int IDX_W   = 4;             // point_index port width
  localparam int CNT_W   = 5;             // point_count register width
  localparam int BIN_W   = 30;            // holds C(31,15)
  localparam int PROD_W  = Q_W + 1 + COORD_W;

  localparam logic [Q_W-1:0]   ONE_Q16   = Q_W'(65536);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4);
  localparam int               SEG_RESET = 150;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  typedef enum logic [0:0] {
    REG_POINT_COUNT = 1'b0,
    REG_SEGMENTS    = 1'b1
  } cfg_reg_t;

  // Item riding down the pipeline next to its valid bit.
  typedef struct packed {
    logic                      load;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } item_t;

  // Q0.16 product, rounded half up.
  function automatic logic [Q_W-1:0] pow_mul(input logic [Q_W-1:0] a,
                                             input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] p;
    p = (2*Q_W)'(a) * (2*Q_W)'(b) + (2*Q_W)'(32768);
    return p[Q_W+15:16];
  endfunction

  // Binomial coefficient by Pascal rows; used on constants only.
  function automatic longint binom(input int n, input int k);
    longint row [33];
    for (int a = 0; a < 33; a++) row[a] = 0;
    row[0] = 1;
    for (int r = 1; r <= n; r++) begin
      for (int c = r; c > 0; c--) row[c] = row[c] + row[c-1];
    end
    return row[k];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bezier_curve_evaluator.sv
// ----------------------------------------------------------------------------
// bezier_curve_evaluator
// Bezier curve point evaluator in Bernstein form, fully pipelined.
// ----------------------------------------------------------------------------
// The block keeps up to MAX_POINTS control points (signed Q2.14 x and y) and
// answers one curve point per evaluate item: sum over i of
// C(n,i) (1-t)^(n-i) t^i P_i, with t = sample_index / segments (rounded to
// Q0.16, the index saturated at segments, zero segments taken as one) and
// n = point_count - 1, at most MAX_POINTS - 1. A load item writes one point
// and gives no result; an evaluate with point_count of zero gives none
// either. Items of both kinds enter a single pipeline, so a new item is
// taken in every cycle the output side is not stalled; loads are committed
// in item order, so an evaluate sees exactly the loads before it. An item
// passes the divider (one input stage and one quotient bit a stage for 17
// bits), the power ladder (MAX_POINTS stages), the registers for the power
// products, binomial weights and lane products, the adder tree
// (clog2(MAX_POINTS) levels) and the round and saturate register; the divider
// and the power ladder are the deepest parts. Throughput is one item per cycle
// while no result is held; a stalled result holds the whole pipeline.
// Configuration (point_count, segments) is sampled live and must only be
// written while the block is empty. Slots never loaded read as undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_curve_evaluator import bcv_pkg::*; #(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CFG_W       = (SAMPLE_BITS > CNT_W) ? SAMPLE_BITS : CNT_W
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration write port
  input  wire logic                      cfg_write,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data,
  // input item channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      opcode,
  input  wire logic [IDX_W-1:0]          point_index,
  input  wire logic signed [COORD_W-1:0] point_x,
  input  wire logic signed [COORD_W-1:0] point_y,
  input  wire logic [SAMPLE_BITS-1:0]    sample_index,
  // result item channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [COORD_W-1:0]      curve_x,
  output logic signed [COORD_W-1:0]      curve_y
);

  localparam int NW = $clog2(MAX_POINTS);
  localparam int AW = PROD_W + NW;
  localparam int RW = AW - 16;

  logic [CNT_W-1:0]       point_count;
  logic [SAMPLE_BITS-1:0] segments;
  logic [SAMPLE_BITS-1:0] seg_eff;
  logic [SAMPLE_BITS-1:0] j_sat;
  logic [NW-1:0]          n;
  logic                   en;
  item_t                  in_item;

  logic                   d_vld, p_vld, b_vld, b_load;
  item_t                  d_item, p_item;
  logic [Q_W-1:0]         t;
  logic [Q_W-1:0]         tp [MAX_POINTS];
  logic [Q_W-1:0]         up [MAX_POINTS];
  logic signed [AW-1:0]   acc_x, acc_y;
  logic signed [RW-1:0]   rx, ry;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CNT_RESET;
      segments    <= SAMPLE_BITS'(SEG_RESET);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POINT_COUNT: point_count <= cfg_data[CNT_W-1:0];
        REG_SEGMENTS:    segments    <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Zero segments acts as one; clamp the sample index and the point count.
  assign seg_eff = (segments == '0) ? SAMPLE_BITS'(1) : segments;
  assign j_sat   = (sample_index > seg_eff) ? seg_eff : sample_index;
  assign n       = (int'(point_count) > MAX_POINTS) ? NW'(MAX_POINTS - 1)
                                                    : NW'(point_count - CNT_W'(1));

  // Whole pipeline advances unless a finished result is held.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign in_item.load = (opcode_t'(opcode) == OP_LOAD);
  assign in_item.idx  = point_index;
  assign in_item.x    = point_x;
  assign in_item.y    = point_y;

  bcv_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (in_valid),
    .in_item  (in_item),
    .j        (j_sat),
    .seg      (seg_eff),
    .out_vld  (d_vld),
    .out_item (d_item),
    .t        (t)
  );

  bcv_pow #(
    .MAX_POINTS (MAX_POINTS)
  ) u_pow (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (d_vld),
    .in_item  (d_item),
    .t        ((t > ONE_Q16) ? ONE_Q16 : t),
    .out_vld  (p_vld),
    .out_item (p_item),
    .tp       (tp),
    .up       (up)
  );

  bcv_blend #(
    .MAX_POINTS (MAX_POINTS),
    .NW         (NW),
    .AW         (AW)
  ) u_blend (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (p_vld),
    .in_item  (p_item),
    .tp       (tp),
    .up       (up),
    .n        (n),
    .out_vld  (b_vld),
    .out_load (b_load),
    .acc_x    (acc_x),
    .acc_y    (acc_y)
  );

  // Round half up by 16 bits.
  assign rx = RW'((acc_x + AW'(32768)) >>> 16);
  assign ry = RW'((acc_y + AW'(32768)) >>> 16);

  // Output register: drop loads and evaluates with no points in use.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_vld && !b_load && (point_count != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      curve_x <= (rx > RW'(32767))  ? COORD_W'(32767)  :
                 (rx < -RW'(32768)) ? -COORD_W'(32768) : rx[COORD_W-1:0];
      curve_y <= (ry > RW'(32767))  ? COORD_W'(32767)  :
                 (ry < -RW'(32768)) ? -COORD_W'(32768) : ry[COORD_W-1:0];
    end
  end

  // A stall toward the input only comes from a held result.
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  // A held result is never dropped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("held result lost");

  // A held result does not change.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(curve_x) && $stable(curve_y))
    else $error("held result changed");

endmodule

`default_nettype wire

FILE: hw/rtl/bcv_div.sv
// ----------------------------------------------------------------------------
// bcv_div
// Pipelined restoring divider: t = round(j * 65536 / segments), one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bcv_div import bcv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_vld,
  input  wire item_t                  in_item,
  input  wire logic [SAMPLE_BITS-1:0] j,
  input  wire logic [SAMPLE_BITS-1:0] seg,
  output logic                        out_vld,
  output item_t                       out_item,
  output logic [Q_W-1:0]              t
);

  localparam int NUMW = SAMPLE_BITS + Q_W;

  logic            vld [Q_W+1];
  item_t           it  [Q_W+1];
  logic [NUMW-1:0] rem [Q_W+1];
  logic [Q_W-1:0]  q   [Q_W+1];

  // Stage 0: numerator with the half-divisor rounding term.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it[0]  <= in_item;
      rem[0] <= (NUMW'(j) << 16) + NUMW'(seg >> 1);
      q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_bit
    localparam int B = Q_W - k;
    logic [NUMW-1:0] dsh;
    logic            ge;

    assign dsh = NUMW'(seg) << B;
    assign ge  = rem[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it[k]  <= it[k-1];
        rem[k] <= ge ? rem[k-1] - dsh : rem[k-1];
        q[k]   <= q[k-1] | (ge ? (Q_W'(1) << B) : '0);
      end
    end
  end

  assign out_vld  = vld[Q_W];
  assign out_item = it[Q_W];
  assign t        = q[Q_W];

endmodule

`default_nettype wire

FILE: hw/rtl/bcv_pow.sv
// ----------------------------------------------------------------------------
// bcv_pow
// Power ladder: one new power of t and of 1-t per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bcv_pow import bcv_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire item_t          in_item,
  input  wire logic [Q_W-1:0] t,
  output logic                out_vld,
  output item_t               out_item,
  output logic [Q_W-1:0]      tp [MAX_POINTS],
  output logic [Q_W-1:0]      up [MAX_POINTS]
);

  logic           vld [MAX_POINTS];
  item_t          it  [MAX_POINTS];
  logic [Q_W-1:0] tt  [MAX_POINTS];
  logic [Q_W-1:0] uu  [MAX_POINTS];
  logic [Q_W-1:0] tps [MAX_POINTS][MAX_POINTS];
  logic [Q_W-1:0] ups [MAX_POINTS][MAX_POINTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it[0] <= in_item;
      tt[0] <= t;
      uu[0] <= ONE_Q16 - t;
      for (int k = 0; k < MAX_POINTS; k++) begin
        tps[0][k] <= ONE_Q16;
        ups[0][k] <= ONE_Q16;
      end
    end
  end

  for (genvar s = 1; s < MAX_POINTS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it[s] <= it[s-1];
        tt[s] <= tt[s-1];
        uu[s] <= uu[s-1];
        for (int k = 0; k < MAX_POINTS; k++) begin
          if (k == s) begin
            tps[s][k] <= pow_mul(tps[s-1][k-1], tt[s-1]);
            ups[s][k] <= pow_mul(ups[s-1][k-1], uu[s-1]);
          end else begin
            tps[s][k] <= tps[s-1][k];
            ups[s][k] <= ups[s-1][k];
          end
        end
      end
    end
  end

  assign out_vld  = vld[MAX_POINTS-1];
  assign out_item = it[MAX_POINTS-1];
  assign tp       = tps[MAX_POINTS-1];
  assign up       = ups[MAX_POINTS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/bcv_blend.sv
// ----------------------------------------------------------------------------
// bcv_blend
// Bernstein weights, control point store and the registered weighted-sum tree.
// ----------------------------------------------------------------------------
`default_nettype none

module bcv_blend import bcv_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int NW         = $clog2(MAX_POINTS),
  parameter int AW         = PROD_W + NW
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire item_t          in_item,
  input  wire logic [Q_W-1:0] tp [MAX_POINTS],
  input  wire logic [Q_W-1:0] up [MAX_POINTS],
  input  wire logic [NW-1:0]  n,
  output logic                out_vld,
  output logic                out_load,
  output logic signed [AW-1:0] acc_x,
  output logic signed [AW-1:0] acc_y
);

  localparam int P2 = 1 << NW;

  logic                      vld1, vld2;
  item_t                     it1;
  logic                      ld2;
  logic [Q_W-1:0]            pw  [MAX_POINTS];
  logic [Q_W-1:0]            w   [MAX_POINTS];
  logic signed [COORD_W-1:0] px  [MAX_POINTS];
  logic signed [COORD_W-1:0] py  [MAX_POINTS];
  logic [2*COORD_W-1:0]      pts [MAX_POINTS];
  logic                      vt  [NW+1];
  logic                      lt  [NW+1];
  logic signed [AW-1:0]      sx  [NW+1][P2];
  logic signed [AW-1:0]      sy  [NW+1][P2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
      vld2 <= vld1;
    end
  end

  // Control point store; loads land here, in order with the evaluates.
  always_ff @(posedge clk) begin
    if (en && vld1 && it1.load && int'(it1.idx) < MAX_POINTS) begin
      pts[NW'(it1.idx)] <= {it1.y, it1.x};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1 <= in_item;
      ld2 <= it1.load;
    end
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_lane
    logic [BIN_W-1:0]       btab [MAX_POINTS];
    logic [BIN_W-1:0]       bsel;
    logic [Q_W+BIN_W-1:0]   wp;
    logic [NW-1:0]          ui;

    for (genvar m = 0; m < MAX_POINTS; m++) begin : g_bin
      assign btab[m] = BIN_W'(binom(m, i));
    end

    assign ui   = n - NW'(i);
    assign bsel = btab[n];
    assign wp   = (Q_W+BIN_W)'(pw[i]) * (Q_W+BIN_W)'(bsel);

    always_ff @(posedge clk) begin
      if (en) begin
        // Stage 1: power product, zero for lanes past the degree.
        pw[i] <= (NW'(i) > n) ? '0 : pow_mul(up[ui], tp[i]);
        // Stage 2: binomial weight, clamp at 1.0; latch the point, zero past
        // the degree so slots outside the curve never reach the sum.
        w[i]  <= (wp > (Q_W+BIN_W)'(ONE_Q16)) ? ONE_Q16 : wp[Q_W-1:0];
        px[i] <= (NW'(i) > n) ? '0 : pts[i][COORD_W-1:0];
        py[i] <= (NW'(i) > n) ? '0 : pts[i][2*COORD_W-1:COORD_W];
      end
    end
  end

  // Stage 3: lane products form level 0 of the sum tree.
  always_ff @(posedge clk) begin
    if (rst) begin
      vt[0] <= 1'b0;
    end else if (en) begin
      vt[0] <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lt[0] <= ld2;
      for (int k = 0; k < P2; k++) begin
        if (k < MAX_POINTS) begin
          sx[0][k] <= AW'(signed'({1'b0, w[k]}) * px[k]);
          sy[0][k] <= AW'(signed'({1'b0, w[k]}) * py[k]);
        end else begin
          sx[0][k] <= '0;
          sy[0][k] <= '0;
        end
      end
    end
  end

  for (genvar l = 1; l <= NW; l++) begin : g_lvl
    always_ff @(posedge clk) begin
      if (rst) begin
        vt[l] <= 1'b0;
      end else if (en) begin
        vt[l] <= vt[l-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lt[l] <= lt[l-1];
        for (int k = 0; k < (P2 >> l); k++) begin
          sx[l][k] <= sx[l-1][2*k] + sx[l-1][2*k+1];
          sy[l][k] <= sy[l-1][2*k] + sy[l-1][2*k+1];
        end
      end
    end
  end

  assign out_vld  = vt[NW];
  assign out_load = lt[NW];
  assign acc_x    = sx[NW][0];
  assign acc_y    = sy[NW][0];

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression bench of the Bezier curve evaluator: directed and random items,
// a bit-exact prediction of every curve point, random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import bcv_pkg::*;

  localparam int NPTS   = 16;
  localparam int LAT    = 60;     // above the pipeline depth
  localparam int WD_MAX = 20000;  // cycles without any accepted item

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = REG_POINT_COUNT;
  logic [9:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_LOAD;
  logic [3:0] point_index = '0;
  logic signed [15:0] point_x = '0;
  logic signed [15:0] point_y = '0;
  logic [9:0] sample_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] curve_x, curve_y;

  bezier_curve_evaluator dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .point_index(point_index), .point_x(point_x), .point_y(point_y),
    .sample_index(sample_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .curve_x(curve_x), .curve_y(curve_y)
  );

  always #6 clk = ~clk;

  // Shadow of the block's state and configuration.
  logic [15:0] px [NPTS];
  logic [15:0] py [NPTS];
  logic [4:0]  shadow_count;
  logic [9:0]  shadow_segs;

  logic [31:0] curve_q[$];   // expected {x, y}, oldest first
  int  errors = 0;
  bit  quiet = 1'b0;         // last part of the run: no idling
  int  idle_cycles = 0;
  int  stall_left = 0;

  function automatic logic [16:0] q16_mul(logic [16:0] a, logic [16:0] b);
    logic [33:0] p;
    p = 34'(a) * 34'(b) + 34'd32768;
    return p[32:16];
  endfunction

  function automatic logic [15:0] round_q14(longint acc);
    longint r;
    r = (acc + 64'sd32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Curve point for sample j under the shadow configuration.
  function automatic logic [31:0] bezier_point(logic [9:0] j_in);
    int cnt, n, seg;
    longint j, t, u, binom, w, ax, ay;
    logic [16:0] tp [NPTS];
    logic [16:0] up [NPTS];
    cnt = shadow_count;
    if (cnt > NPTS) cnt = NPTS;
    if (cnt == 1) return {px[0], py[0]};
    seg = (shadow_segs == 0) ? 1 : shadow_segs;
    j = j_in;
    if (j > seg) j = seg;
    t = (j * 65536 + seg / 2) / seg;
    if (t > 65536) t = 65536;
    u = 65536 - t;
    n = cnt - 1;
    tp[0] = ONE_Q16;
    up[0] = ONE_Q16;
    for (int i = 1; i <= n; i++) begin
      tp[i] = q16_mul(tp[i-1], 17'(t));
      up[i] = q16_mul(up[i-1], 17'(u));
    end
    binom = 1; ax = 0; ay = 0;
    for (int i = 0; i <= n; i++) begin
      if (i > 0) binom = binom * (n - i + 1) / i;
      w = longint'(q16_mul(up[n-i], tp[i])) * binom;
      if (w > 65536) w = 65536;
      ax += w * longint'($signed(px[i]));
      ay += w * longint'($signed(py[i]));
    end
    return {round_q14(ax), round_q14(ay)};
  endfunction

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Send one item; predict once it is accepted. Valid stays high so the
  // next item can follow back to back.
  task automatic send_item(logic op, logic [3:0] idx, logic [15:0] x,
                           logic [15:0] y, logic [9:0] j);
    idle_burst();
    in_valid <= 1'b1;
    opcode <= op;
    point_index <= idx;
    point_x <= x;
    point_y <= y;
    sample_index <= j;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) begin
      px[idx] = x;
      py[idx] = y;
    end else if (shadow_count != 0) begin
      curve_q = {curve_q, bezier_point(j)};
    end
  endtask

  task automatic load_point(int idx, logic [15:0] x, logic [15:0] y);
    send_item(OP_LOAD, 4'(idx), x, y, 10'($urandom));
  endtask

  task automatic eval_sample(logic [9:0] j);
    send_item(OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), j);
  endtask

  // Drop valid, drain, pause past the latency, then write one register.
  task automatic write_reg(cfg_reg_t r, logic [9:0] v);
    in_valid <= 1'b0;
    while (curve_q.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (r == REG_POINT_COUNT) shadow_count = v[4:0];
    else shadow_segs = v;
  endtask

  // Result checker and output stall generator.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (curve_q.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h", $time, curve_x, curve_y);
          errors++;
        end else begin
          want = curve_q.pop_front();
          if (curve_x !== want[31:16]) begin
            $display("%0t: curve_x expected %h actual %h", $time, want[31:16], curve_x);
            errors++;
          end
          if (curve_y !== want[15:0]) begin
            $display("%0t: curve_y expected %h actual %h", $time, want[15:0], curve_y);
            errors++;
          end
        end
      end
      // start a stall burst at random and hold it while stall_left runs down
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 5);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog over cycles with no accepted item on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_MAX) begin
      $display("bezier_curve_evaluator regression: fail");
      $finish;
    end
  end

  // Fill every slot the count needs so nothing undefined is ever read.
  task automatic fill_points(int cnt);
    for (int i = 0; i < cnt; i++)
      load_point(i, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    // extremes of the coordinates, all in slots that will be read
    load_point(0, 16'h7fff, 16'h8000);
    load_point(1, 16'h8000, 16'h7fff);
    load_point(2, 16'h7fff, 16'h7fff);
    load_point(3, 16'h8000, 16'h8000);
    eval_sample(10'd0);
    eval_sample(10'd75);
    eval_sample(10'd150);
    eval_sample(10'd1023);     // sample past end saturates
    write_reg(REG_POINT_COUNT, 10'd1);   // single point
    eval_sample(10'd40);
    write_reg(REG_POINT_COUNT, 10'd0);   // no points: no result
    eval_sample(10'd3);
    load_point(15, 16'h0000, 16'hffff);
    write_reg(REG_POINT_COUNT, 10'd31);  // above the limit acts as 16
    fill_points(NPTS);
    write_reg(REG_SEGMENTS, 10'd0);      // zero segments acts as 1
    eval_sample(10'd0);
    eval_sample(10'd1);
    write_reg(REG_SEGMENTS, 10'd1023);
    eval_sample(10'd511);
    eval_sample(10'd1023);
    write_reg(REG_POINT_COUNT, 10'd2);
    eval_sample(10'd1);
  endtask

  task automatic test_random(int items);
    int cnt, left;
    left = items;
    while (left > 0) begin
      cnt = $urandom_range(0, 9) == 0 ? $urandom_range(17, 31) : $urandom_range(1, 16);
      write_reg(REG_POINT_COUNT, 10'(cnt));
      write_reg(REG_SEGMENTS, $urandom_range(0, 3) == 0 ? 10'($urandom) :
                10'($urandom_range(1, 40)));
      fill_points(cnt > NPTS ? NPTS : cnt);
      left -= (cnt > NPTS ? NPTS : cnt);
      repeat ($urandom_range(10, 60)) begin
        if ($urandom_range(0, 7) == 0)
          load_point($urandom_range(0, NPTS - 1), 16'($urandom), 16'($urandom));
        else if ($urandom_range(0, 4) == 0)
          eval_sample(10'($urandom));
        else
          eval_sample(10'($urandom_range(0, shadow_segs)));
        left--;
      end
      if (left < 300) quiet = 1'b1;
    end
  endtask

  initial begin
    shadow_count = CNT_RESET;
    shadow_segs = 10'(SEG_RESET);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1630);
    quiet = 1'b1;
    in_valid <= 1'b0;
    while (curve_q.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
    if (errors == 0 && curve_q.size() == 0)
      $display("bezier_curve_evaluator regression: pass");
    else
      $display("bezier_curve_evaluator regression: fail");
    $finish;
  end
endmodule

FILE: bezier_curve_evaluator.f
hw/rtl/bcv_pkg.sv
hw/rtl/bcv_div.sv
hw/rtl/bcv_pow.sv
hw/rtl/bcv_blend.sv
hw/rtl/bezier_curve_evaluator.sv
tb/sv/tb.sv
